// ===== design/lsmt_pkg.sv =====
package lsmt_pkg;

  // Scanline timing.
  localparam logic [9:0] DOTS_PER_LINE = 10'd456;
  localparam logic [7:0] VISIBLE_LINES = 8'd144;
  localparam logic [7:0] LAST_LINE     = 8'd153;
  localparam logic [9:0] OAM_END       = 10'd80;
  localparam logic [9:0] TRANSFER_END  = 10'd252;

  // The dot counter saturates here before a line is taken off.
  localparam logic [9:0] DOT_SAT = 10'd1023;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_SCREEN_ON    = 2'd0,
    REG_LINE_COMPARE = 2'd1,
    REG_MODE_IRQ_EN  = 2'd2,
    REG_COINC_IRQ_EN = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic       screen_on;
    logic [7:0] line_compare;
    logic [2:0] mode_irq_enable;
    logic       coincidence_irq_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] line;
    mode_e      mode;
    logic       coincidence;
    logic       vblank_irq;
    logic       stat_irq;
  } res_t;

endpackage

// ===== design/lsmt_cfg_regs.sv =====
module lsmt_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [7:0]      cfg_data_i,
  output lsmt_pkg::cfg_t  cfg_o
);
  import lsmt_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_SCREEN_ON:    cfg_d.screen_on              = cfg_data_i[0];
        REG_LINE_COMPARE: cfg_d.line_compare           = cfg_data_i;
        REG_MODE_IRQ_EN:  cfg_d.mode_irq_enable        = cfg_data_i[2:0];
        REG_COINC_IRQ_EN: cfg_d.coincidence_irq_enable = cfg_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_on              <= 1'b1;
      cfg_q.line_compare           <= 8'd0;
      cfg_q.mode_irq_enable        <= 3'd0;
      cfg_q.coincidence_irq_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/lsmt_core.sv =====
module lsmt_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [3:0]      cycles_i,
  input  lsmt_pkg::cfg_t  cfg_i,
  output lsmt_pkg::res_t  res_o
);
  import lsmt_pkg::*;

  logic [9:0] dot_q, dot_d;
  logic [7:0] line_q, line_d;
  mode_e      last_q, last_d;
  mode_e      shown_q, shown_d;

  logic [10:0] dot_sum;
  logic [9:0]  dot_sat;
  logic [8:0]  line_inc;
  mode_e       mode;
  mode_e       shown_pre;
  logic        changed;
  logic        mode_en;
  logic        coincident;

  always_comb begin
    dot_sum = {1'b0, dot_q} + {5'd0, cycles_i, 2'b00};
    dot_sat = dot_sum[10] ? DOT_SAT : dot_sum[9:0];

    // Mode from the line and the dot position after the add.
    if (line_q >= VISIBLE_LINES) begin
      mode = MODE_VBLANK;
    end else if (dot_sat < OAM_END) begin
      mode = MODE_OAM;
    end else if (dot_sat < TRANSFER_END) begin
      mode = MODE_XFER;
    end else if (dot_sat < DOTS_PER_LINE) begin
      mode = MODE_HBLANK;
    end else begin
      mode = MODE_OAM;
    end

    shown_pre = cfg_i.screen_on ? shown_q : MODE_VBLANK;
    changed   = (mode != last_q);
    shown_d   = changed ? mode : shown_pre;
    last_d    = mode;

    unique case (mode)
      MODE_HBLANK: mode_en = cfg_i.mode_irq_enable[0];
      MODE_VBLANK: mode_en = cfg_i.mode_irq_enable[1];
      MODE_OAM:    mode_en = cfg_i.mode_irq_enable[2];
      MODE_XFER:   mode_en = 1'b0;
      default:     mode_en = 1'b0;
    endcase

    coincident = (line_q == cfg_i.line_compare);

    line_inc = {1'b0, line_q} + 9'd1;
    if (dot_sat >= DOTS_PER_LINE) begin
      dot_d  = dot_sat - DOTS_PER_LINE;
      line_d = (line_inc > {1'b0, LAST_LINE}) ? 8'd0 : line_inc[7:0];
    end else begin
      dot_d  = dot_sat;
      line_d = line_q;
    end

    res_o.line        = line_d;
    res_o.mode        = shown_d;
    res_o.coincidence = coincident;
    res_o.vblank_irq  = changed && (mode == MODE_VBLANK);
    res_o.stat_irq    = (changed && mode_en) ||
                        (coincident && cfg_i.coincidence_irq_enable);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q   <= 10'd0;
      line_q  <= 8'd0;
      last_q  <= MODE_OAM;
      shown_q <= MODE_OAM;
    end else if (fire_i) begin
      dot_q   <= dot_d;
      line_q  <= line_d;
      last_q  <= last_d;
      shown_q <= shown_d;
    end
  end

`ifndef SYNTHESIS
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q <= LAST_LINE)
    else $error("line counter past the last line");

  a_dot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dot_q <= (DOT_SAT - DOTS_PER_LINE))
    else $error("dot counter out of range after a step");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(dot_q) && $stable(line_q) && $stable(last_q))
    else $error("timing state moved without a beat");

  a_vblank_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.vblank_irq |-> last_q != MODE_VBLANK)
    else $error("vblank interrupt without a mode change");
`endif

endmodule

// ===== design/lcd_scanline_mode_timer_top.sv =====
// Channel  | valid       | stall        | payload
// ---------+-------------+--------------+--------------------------------------
// in       | in_valid_i  | in_stall_o   | machine_cycles_i
// out      | out_valid_o | out_stall_i  | current_line_o, reported_mode_o,
//          |             |              | coincidence_o, vblank_irq_o, stat_irq_o
// cfg      | cfg_we_i    | (none)       | cfg_index_i, cfg_data_i
//
// One beat is taken every cycle that in_stall_o is low; its result is presented
// from the output register once the input register has passed it on.
// The input register feeds one pass of add, compare and counter update in the
// core, whose result lands in the output register.
// Reset (rst_ni low, asynchronous) empties both registers and sets line 0,
// dot 0, mode OAM search, screen on and all interrupt enables off.
// A stall on the output holds the result register and backs up into the input
// register; in_stall_o rises only when both are full.
module lcd_scanline_mode_timer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] machine_cycles_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] current_line_o,
  output logic [1:0] reported_mode_o,
  output logic       coincidence_o,
  output logic       vblank_irq_o,
  output logic       stat_irq_o
);
  import lsmt_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;

  logic       in_valid_q;
  logic [3:0] cycles_q;
  logic       out_valid_q;
  logic       out_free;
  logic       fire;
  logic       in_take;

  // The output register can load when it is empty or its beat leaves now.
  assign out_free   = !out_valid_q || !out_stall_i;
  // The held input beat is processed and moved into the output register.
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  lsmt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lsmt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .cycles_i (cycles_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cycles_q <= machine_cycles_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_line_o  = res_q.line;
  assign reported_mode_o = res_q.mode;
  assign coincidence_o   = res_q.coincidence;
  assign vblank_irq_o    = res_q.vblank_irq;
  assign stat_irq_o      = res_q.stat_irq;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lsmt_pkg::*;

  // Random ticks per configuration phase, and the number of such phases.
  localparam int unsigned PHASE_TICKS = 244;
  localparam int unsigned PHASES      = 8;
  // Cycles with no beat on any port before the run is declared hung.
  localparam int unsigned HANG_LIMIT  = 5000;
  // Results trail their input beat through the input and output registers; allow a little slack.
  localparam int unsigned SETTLE      = 4;

  // Scoreboard: a cycle-free copy of the scanline timer plus the queue of
  // status words that the block still owes us.
  class scanline_scoreboard;
    cfg_t        regs;
    logic [9:0]  dot_q;
    logic [7:0]  line_q;
    mode_e       last_mode_q;
    mode_e       shown_mode_q;
    res_t        pending_status[$];
    int unsigned mismatches;

    function new();
      regs.screen_on              = 1'b1;
      regs.line_compare           = 8'd0;
      regs.mode_irq_enable        = 3'd0;
      regs.coincidence_irq_enable = 1'b0;
      dot_q        = 10'd0;
      line_q       = 8'd0;
      last_mode_q  = MODE_OAM;
      shown_mode_q = MODE_OAM;
      mismatches   = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [7:0] data);
      case (idx)
        REG_SCREEN_ON:    regs.screen_on              = data[0];
        REG_LINE_COMPARE: regs.line_compare           = data;
        REG_MODE_IRQ_EN:  regs.mode_irq_enable        = data[2:0];
        REG_COINC_IRQ_EN: regs.coincidence_irq_enable = data[0];
        default: ;
      endcase
    endfunction

    function mode_e mode_now();
      if (line_q >= VISIBLE_LINES) return MODE_VBLANK;
      if (dot_q < OAM_END) return MODE_OAM;
      if (dot_q < TRANSFER_END) return MODE_XFER;
      if (dot_q < DOTS_PER_LINE) return MODE_HBLANK;
      return MODE_OAM;
    endfunction

    // Advance the timer by one accepted tick and queue the status it yields.
    function void note_tick(logic [3:0] cycles);
      logic [10:0] dots;
      mode_e       mode;
      res_t        status;
      status = '0;
      dots = {1'b0, dot_q} + {5'd0, cycles, 2'b00};
      if (dots > {1'b0, DOT_SAT}) dots = {1'b0, DOT_SAT};
      dot_q = dots[9:0];
      if (!regs.screen_on) shown_mode_q = MODE_VBLANK;
      mode = mode_now();
      if (mode != last_mode_q) begin
        shown_mode_q = mode;
        last_mode_q  = mode;
        if (mode == MODE_VBLANK) status.vblank_irq = 1'b1;
        if (mode != MODE_XFER) begin
          if (regs.mode_irq_enable[mode]) status.stat_irq = 1'b1;
        end
      end
      status.coincidence = (line_q == regs.line_compare);
      if (status.coincidence && regs.coincidence_irq_enable) status.stat_irq = 1'b1;
      if (dot_q >= DOTS_PER_LINE) begin
        dot_q  = dot_q - DOTS_PER_LINE;
        line_q = (line_q >= LAST_LINE) ? 8'd0 : line_q + 8'd1;
      end
      status.line = line_q;
      status.mode = shown_mode_q;
      pending_status.push_back(status);
    endfunction

    function void flag(string what, res_t want, res_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: want line %0d mode %0d coin %0b vbl %0b stat %0b, got line %0d mode %0d coin %0b vbl %0b stat %0b",
                 $realtime, what, want.line, want.mode, want.coincidence,
                 want.vblank_irq, want.stat_irq, got.line, got.mode, got.coincidence,
                 got.vblank_irq, got.stat_irq);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_status.size() == 0) begin
        flag("status with no tick pending", '0, got);
      end else begin
        want = pending_status.pop_front();
        if (got.line !== want.line || got.mode !== want.mode ||
            got.coincidence !== want.coincidence || got.vblank_irq !== want.vblank_irq ||
            got.stat_irq !== want.stat_irq)
          flag("status mismatch", want, got);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni           = 1'b0;
  logic       cfg_we_i         = 1'b0;
  logic [1:0] cfg_index_i      = 2'd0;
  logic [7:0] cfg_data_i       = 8'd0;
  logic       in_valid_i       = 1'b0;
  logic       in_stall_o;
  logic [3:0] machine_cycles_i = 4'd0;
  logic       out_valid_o;
  logic       out_stall_i      = 1'b0;
  logic [7:0] current_line_o;
  logic [1:0] reported_mode_o;
  logic       coincidence_o;
  logic       vblank_irq_o;
  logic       stat_irq_o;

  scanline_scoreboard sb;
  int unsigned        quiet_cycles = 0;
  int unsigned        stall_left   = 0;
  int unsigned        stall_style  = 0;

  lcd_scanline_mode_timer_top uut (.*);

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // The receiver stalls in styles that change at random intervals:
  // never, sparsely, on a fixed rhythm, or almost always. This moves the
  // back-pressure across every phase of the two-stage pipe.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(32, 256);
    end else begin
      stall_left--;
    end
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= stall_left[1];
      default: out_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Monitor. Everything is sampled at the rising edge, before the testbench's
  // own nonblocking updates land, so each beat is seen exactly as the block
  // saw it. The hang watchdog lives here too: any beat on any port resets it.
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_tick(machine_cycles_i);
      if (out_valid_o && !out_stall_i) begin
        got.line        = current_line_o;
        got.mode        = mode_e'(reported_mode_o);
        got.coincidence = coincidence_o;
        got.vblank_irq  = vblank_irq_o;
        got.stat_irq    = stat_irq_o;
        sb.check_result(got);
      end
      if (cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == HANG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Present one tick and hold it until the block takes the beat. The caller
  // is always at a rising edge, so valid is raised or kept by a single
  // assignment in this time step.
  task automatic send_tick(input logic [3:0] cycles);
    in_valid_i       <= 1'b1;
    machine_cycles_i <= cycles;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Every tick yields a status word, so once the queue is empty the pipe is
  // empty too; a few extra cycles catch any stray result.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_status.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  // All four registers are written back to back; unused data bits carry
  // noise so the block's masking is exercised.
  task automatic load_config(input cfg_t setting);
    put_reg(REG_SCREEN_ON, {7'($urandom), setting.screen_on});
    put_reg(REG_LINE_COMPARE, setting.line_compare);
    put_reg(REG_MODE_IRQ_EN, {5'($urandom), setting.mode_irq_enable});
    put_reg(REG_COINC_IRQ_EN, {7'($urandom), setting.coincidence_irq_enable});
    cfg_we_i <= 1'b0;
  endtask

  // Long ticks dominate so that the run sweeps through whole frames, vblank
  // and the wrap back to line 0 included; the rest covers the full range.
  function automatic logic [3:0] tick_length();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 4'd15;
    if (roll < 8) return 4'($urandom_range(8, 15));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic run_bursts(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      while (burst != 0 && sent < count) begin
        send_tick(tick_length());
        sent++;
        burst--;
      end
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
    end
  endtask

  // Phase zero uses the low end of every register and phase one the high
  // end; the others are random, with the screen mostly on and the compare
  // value mostly on a line that actually occurs.
  task automatic random_phase(input int unsigned phase);
    cfg_t setting;
    case (phase)
      0: setting = '0;
      1: setting = '{screen_on: 1'b1, line_compare: 8'd255, mode_irq_enable: 3'd7,
                     coincidence_irq_enable: 1'b1};
      default: begin
        setting.screen_on              = ($urandom_range(0, 4) != 0);
        setting.line_compare           = ($urandom_range(0, 3) == 0) ?
                                         8'($urandom_range(0, 255)) :
                                         8'($urandom_range(0, 153));
        setting.mode_irq_enable        = 3'($urandom_range(0, 7));
        setting.coincidence_irq_enable = 1'($urandom_range(0, 1));
      end
    endcase
    wait_idle();
    load_config(setting);
    run_bursts(PHASE_TICKS);
  endtask

  initial begin
    cfg_t setting;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the reset settings: an empty tick, then long ticks that walk
    // through OAM search, transfer and hblank into line 1.
    send_tick(4'd0);
    repeat (8) send_tick(4'd15);
    wait_idle();

    // Compare on line 1 with every interrupt enabled: the coincidence
    // interrupt must fire on every tick of that line, and each mode entry
    // other than transfer raises the status interrupt.
    setting = '{screen_on: 1'b1, line_compare: 8'd1, mode_irq_enable: 3'd7,
                coincidence_irq_enable: 1'b1};
    load_config(setting);
    repeat (8) send_tick(4'd15);
    wait_idle();

    // Screen off: the reported mode is forced to vblank and only a real
    // mode change overrides it. Short ticks toggle each input bit alone.
    setting = '{screen_on: 1'b0, line_compare: 8'd2, mode_irq_enable: 3'd5,
                coincidence_irq_enable: 1'b0};
    load_config(setting);
    send_tick(4'd8);
    send_tick(4'd4);
    send_tick(4'd2);
    send_tick(4'd1);
    send_tick(4'd15);
    send_tick(4'd15);

    for (int unsigned phase = 0; phase < PHASES; phase++) random_phase(phase);

    wait_idle();
    if (sb.mismatches == 0 && sb.pending_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/lsmt_pkg.sv
design/lsmt_cfg_regs.sv
design/lsmt_core.sv
design/lcd_scanline_mode_timer_top.sv
tb/tb_top.sv
